[rtl/core/five_tuple_rule_filter_top_macros.svh]
// ----------------------------------------------------------------------------
// five_tuple_rule_filter_top_macros.svh
// Assertion macros shared by the rule filter modules. Each macro expects the
// signals clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef FIVE_TUPLE_RULE_FILTER_TOP_MACROS_SVH
`define FIVE_TUPLE_RULE_FILTER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FTRF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FTRF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ftrf_pkg.sv]
// ----------------------------------------------------------------------------
// ftrf_pkg
// Types, sizes and codes shared by the five-tuple rule filter.
// ----------------------------------------------------------------------------
package ftrf_pkg;

  // Table size and derived widths.
  localparam int MaxRules = 16;
  localparam int IdxW     = (MaxRules > 1) ? $clog2(MaxRules) : 1;
  localparam int CntW     = $clog2(MaxRules + 1);

  // Fixed field widths of the beats.
  localparam int OpW     = 2;
  localparam int AddrW   = 32;
  localparam int PortW   = 16;
  localparam int ProtoW  = 8;
  localparam int RuleIdW = 4;
  localparam int StatW   = 2;
  localparam int HitW    = 4;
  localparam int CmpW    = (CntW > RuleIdW) ? CntW : RuleIdW;

  // Operation codes.
  typedef enum logic [OpW-1:0] {
    OP_CHECK   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_ENABLE  = 2'd2,
    OP_DISABLE = 2'd3
  } op_t;

  // Result status codes.
  localparam logic [StatW-1:0] STAT_DONE  = 2'd0;
  localparam logic [StatW-1:0] STAT_FULL  = 2'd1;
  localparam logic [StatW-1:0] STAT_RANGE = 2'd2;

  // Match key of a rule or a packet.
  typedef struct packed {
    logic [AddrW-1:0]  src_addr;
    logic [AddrW-1:0]  dst_addr;
    logic [PortW-1:0]  sport;
    logic [PortW-1:0]  dport;
    logic [ProtoW-1:0] proto;
  } key_t;

  // One table entry.
  typedef struct packed {
    key_t key;
    logic action;
    logic enable;
  } rule_t;

  // Rule 0 after reset: enabled all-wildcard deny.
  localparam rule_t DfltRule = '{key: '0, action: 1'b0, enable: 1'b1};

  // Memory ports.
  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    rule_t           data;
  } mem_wr_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
  } mem_rd_t;

  // Scan sequencer request and response.
  typedef struct packed {
    logic            start;
    key_t            key;
    logic [CntW-1:0] count;
  } scan_req_t;

  typedef struct packed {
    logic            done;
    logic            hit;
    logic [IdxW-1:0] index;
    logic            action;
  } scan_rsp_t;

  // Result beat payload.
  typedef struct packed {
    logic [StatW-1:0] status;
    logic             allowed;
    logic             rule_hit;
    logic [HitW-1:0]  hit_index;
  } res_t;

endpackage

[rtl/core/ftrf_if.sv]
// ----------------------------------------------------------------------------
// ftrf_in_if / ftrf_out_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface ftrf_in_if import ftrf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OpW-1:0]     opcode;
  logic [AddrW-1:0]   source_address;
  logic [AddrW-1:0]   dest_address;
  logic [PortW-1:0]   source_port;
  logic [PortW-1:0]   dest_port;
  logic [ProtoW-1:0]  protocol_number;
  logic               rule_action;
  logic [RuleIdW-1:0] rule_index;

  modport source (
    output valid, opcode, source_address, dest_address, source_port,
           dest_port, protocol_number, rule_action, rule_index,
    input  ready
  );
  modport sink (
    input  valid, opcode, source_address, dest_address, source_port,
           dest_port, protocol_number, rule_action, rule_index,
    output ready
  );
endinterface

interface ftrf_out_if import ftrf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [StatW-1:0] status;
  logic             allowed;
  logic             rule_hit;
  logic [HitW-1:0]  hit_index;

  modport source (
    output valid, status, allowed, rule_hit, hit_index,
    input  ready
  );
  modport sink (
    input  valid, status, allowed, rule_hit, hit_index,
    output ready
  );
endinterface

[rtl/core/ftrf_rule_mem.sv]
// ----------------------------------------------------------------------------
// ftrf_rule_mem
// Rule table: one write port, one read port with registered read data.
// Entry 0 reads as the default rule until it is first written.
// ----------------------------------------------------------------------------
module ftrf_rule_mem import ftrf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  mem_wr_t wr,
  input  mem_rd_t rd,
  output rule_t   rd_data
);

  rule_t mem [MaxRules];
  rule_t rd_data_r;
  logic  dflt0_r;
  logic  dflt0_nxt;
  logic  sel_dflt_r;

  // Entry 0 keeps its default view until the first write to it.
  always_comb begin
    dflt0_nxt = dflt0_r;
    if (wr.en && (wr.addr == '0)) begin
      dflt0_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt0_r <= 1'b1;
    end else begin
      dflt0_r <= dflt0_nxt;
    end
  end

  // Array write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r  <= mem[rd.addr];
      sel_dflt_r <= dflt0_r && (rd.addr == '0);
    end
  end

  assign rd_data = sel_dflt_r ? DfltRule : rd_data_r;

endmodule

[rtl/core/ftrf_scan.sv]
// ----------------------------------------------------------------------------
// ftrf_scan
// First-match scan sequencer. Issues one table read per cycle and compares
// the returned rule against the packet key in the cycle after.
// ----------------------------------------------------------------------------
`include "five_tuple_rule_filter_top_macros.svh"

module ftrf_scan import ftrf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  scan_req_t req,
  output mem_rd_t   rd,
  input  rule_t     rd_data,
  output scan_rsp_t rsp
);

  logic            busy_r, busy_nxt;
  logic [CntW-1:0] issue_r, issue_nxt;
  logic            cmp_vld_r, cmp_vld_nxt;
  logic [IdxW-1:0] cmp_idx_r;
  key_t            key_r;
  logic [CntW-1:0] count_r;
  scan_rsp_t       rsp_r, rsp_nxt;
  logic            match;
  logic            last;
  logic            finish;

  // A zero rule field is a wildcard.
  function automatic logic key_hit(input key_t rule_key, input key_t pkt_key);
    logic h;
    h = ((rule_key.src_addr == '0) || (rule_key.src_addr == pkt_key.src_addr)) &&
        ((rule_key.dst_addr == '0) || (rule_key.dst_addr == pkt_key.dst_addr)) &&
        ((rule_key.sport == '0) || (rule_key.sport == pkt_key.sport)) &&
        ((rule_key.dport == '0) || (rule_key.dport == pkt_key.dport)) &&
        ((rule_key.proto == '0) || (rule_key.proto == pkt_key.proto));
    return h;
  endfunction

  // Read issue and compare stage.
  always_comb begin
    rd.en   = busy_r && (issue_r < count_r);
    rd.addr = issue_r[IdxW-1:0];

    match  = cmp_vld_r && rd_data.enable && key_hit(rd_data.key, key_r);
    last   = cmp_vld_r && ((CntW'(cmp_idx_r) + CntW'(1)) == count_r);
    finish = match || last;

    busy_nxt = busy_r;
    if (req.start) begin
      busy_nxt = 1'b1;
    end else if (finish) begin
      busy_nxt = 1'b0;
    end

    issue_nxt = issue_r;
    if (req.start) begin
      issue_nxt = '0;
    end else if (rd.en) begin
      issue_nxt = issue_r + CntW'(1);
    end

    // Reads still in flight after the decision are dropped.
    cmp_vld_nxt = rd.en && !finish;

    rsp_nxt.done   = finish;
    rsp_nxt.hit    = match;
    rsp_nxt.index  = match ? cmp_idx_r : '0;
    rsp_nxt.action = match && rd_data.action;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      cmp_vld_r <= 1'b0;
      rsp_r     <= '0;
      issue_r   <= '0;
    end else begin
      busy_r    <= busy_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      rsp_r     <= rsp_nxt;
      issue_r   <= issue_nxt;
    end
  end

  // Packet key and rule count are held for the whole scan.
  always_ff @(posedge clk) begin
    cmp_idx_r <= rd.addr;
    if (req.start) begin
      key_r   <= req.key;
      count_r <= req.count;
    end
  end

  assign rsp = rsp_r;

  `FTRF_ASSERT_IMP(a_start_idle, req.start, !busy_r, "scan started while busy")
  `FTRF_ASSERT_IMP(a_cmp_busy, cmp_vld_r, busy_r, "compare outside a scan")
  `FTRF_ASSERT_IMP(a_done_idle, rsp_r.done, !busy_r, "scan busy after its result")

endmodule

[rtl/core/five_tuple_rule_filter_top.sv]
// Check: rules are scanned in order up to the first match.
// Append and out-of-range enable or disable go to the output state; in-range ones pass a read-modify-write state.
// The single read port of the rule table sets the scan rate of one rule per cycle.
// One command is in progress at a time; a finished result waits in the output
// register while the next command beat is taken.
// Synchronous active-low reset restores one enabled all-wildcard deny rule at index 0.
// ----------------------------------------------------------------------------
// five_tuple_rule_filter_top
// First-match five-tuple packet filter with append, enable and disable of
// rules kept in a rule table with one write port and one read port.
// ----------------------------------------------------------------------------
`include "five_tuple_rule_filter_top_macros.svh"

module five_tuple_rule_filter_top import ftrf_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  ftrf_in_if.sink    in_ch,
  ftrf_out_if.source out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RMW,
    S_OUT
  } state_t;

  state_t          state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  res_t            res_r, res_nxt;
  res_t            out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            rmw_en_r, rmw_en_nxt;
  logic [IdxW-1:0] rmw_idx_r, rmw_idx_nxt;

  logic            accept;
  op_t             op;
  logic            full;
  logic            in_range;
  key_t            in_key;
  mem_wr_t         mem_wr;
  mem_rd_t         mem_rd;
  mem_rd_t         top_rd;
  mem_rd_t         scan_rd;
  rule_t           mem_rd_data;
  rule_t           wb_rule;
  scan_req_t       scan_req;
  scan_rsp_t       scan_rsp;

  ftrf_rule_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_data (mem_rd_data)
  );

  ftrf_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (scan_req),
    .rd      (scan_rd),
    .rd_data (mem_rd_data),
    .rsp     (scan_rsp)
  );

  // Command decode.
  assign accept   = in_ch.valid && in_ch.ready;
  assign op       = op_t'(in_ch.opcode);
  assign full     = cnt_r >= CntW'(MaxRules);
  assign in_range = CmpW'(in_ch.rule_index) < CmpW'(cnt_r);

  always_comb begin
    in_key.src_addr = in_ch.source_address;
    in_key.dst_addr = in_ch.dest_address;
    in_key.sport    = in_ch.source_port;
    in_key.dport    = in_ch.dest_port;
    in_key.proto    = in_ch.protocol_number;
  end

  // The scan owns the read port while it issues reads.
  assign mem_rd = scan_rd.en ? scan_rd : top_rd;

  // Command sequencer.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    rmw_en_nxt    = rmw_en_r;
    rmw_idx_nxt   = rmw_idx_r;
    mem_wr        = '0;
    top_rd        = '0;
    scan_req      = '0;
    scan_req.key   = in_key;
    scan_req.count = cnt_r;
    wb_rule        = mem_rd_data;
    wb_rule.enable = rmw_en_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt = '0;
          case (op)
            OP_CHECK: begin
              scan_req.start = 1'b1;
              state_nxt      = S_SCAN;
            end
            OP_APPEND: begin
              if (full) begin
                res_nxt.status = STAT_FULL;
              end else begin
                mem_wr.en          = 1'b1;
                mem_wr.addr        = cnt_r[IdxW-1:0];
                mem_wr.data.key    = in_key;
                mem_wr.data.action = in_ch.rule_action;
                mem_wr.data.enable = 1'b1;
                cnt_nxt            = cnt_r + CntW'(1);
              end
              state_nxt = S_OUT;
            end
            OP_ENABLE, OP_DISABLE: begin
              if (in_range) begin
                top_rd.en   = 1'b1;
                top_rd.addr = IdxW'(in_ch.rule_index);
                rmw_en_nxt  = (op == OP_ENABLE);
                rmw_idx_nxt = IdxW'(in_ch.rule_index);
                state_nxt   = S_RMW;
              end else begin
                res_nxt.status = STAT_RANGE;
                state_nxt      = S_OUT;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_rsp.done) begin
          res_nxt.status    = STAT_DONE;
          res_nxt.allowed   = scan_rsp.action;
          res_nxt.rule_hit  = scan_rsp.hit;
          res_nxt.hit_index = HitW'(scan_rsp.index);
          state_nxt         = S_OUT;
        end
      end
      S_RMW: begin
        // Write the entry back with only its enable bit changed.
        mem_wr.en   = 1'b1;
        mem_wr.addr = rmw_idx_r;
        mem_wr.data = wb_rule;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= CntW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload and write-back context need no reset.
  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    out_r     <= out_nxt;
    rmw_en_r  <= rmw_en_nxt;
    rmw_idx_r <= rmw_idx_nxt;
  end

  // Channel outputs.
  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_r.status;
  assign out_ch.allowed   = out_r.allowed;
  assign out_ch.rule_hit  = out_r.rule_hit;
  assign out_ch.hit_index = out_r.hit_index;

  `FTRF_ASSERT_IMP(a_cnt_bound, 1'b1, (cnt_r <= CntW'(MaxRules)) && (|cnt_r), "bad rule count")
  `FTRF_ASSERT_IMP(a_scan_done_state, scan_rsp.done, state_r == S_SCAN, "stray scan result")
  `FTRF_ASSERT_IMP(a_rd_owner, scan_rd.en, !top_rd.en, "read port claimed twice")

endmodule

[verif/five_tuple_rule_filter_top_tb.sv]
// ----------------------------------------------------------------------------
// five_tuple_rule_filter_top_tb
// Self-checking bench for the first-match rule filter. A driver feeds command
// beats from a queue and keeps its own copy of the rule table to predict each
// result beat. A monitor compares every result beat with the oldest
// prediction. Both sides insert random idle cycles.
// ----------------------------------------------------------------------------
module five_tuple_rule_filter_top_tb;
  import ftrf_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 40;
  localparam int RandomCmds = 1850;

  // One command beat as queued for the driver.
  typedef struct {
    op_t                op;
    key_t               key;
    logic               act;
    logic [RuleIdW-1:0] idx;
    bit                 drain;
  } cmd_t;

  logic clk;
  logic rst_n;

  ftrf_in_if  cmd_bus ();
  ftrf_out_if res_bus ();

  five_tuple_rule_filter_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_bus),
    .out_ch (res_bus)
  );

  // Commands waiting to be sent and verdicts waiting to come back.
  cmd_t pending_cmds[$];
  res_t expected_verdicts[$];

  // Shadow copy of the rule table.
  rule_t           shadow_rules[MaxRules];
  logic [CntW-1:0] shadow_count;

  // Field value pools, so that packets and rules often agree.
  logic [31:0] field_pool[5][4];

  cmd_t        cur_cmd;
  int          tx_gap;
  int          rx_stall;
  int          tx_mode;
  int          rx_mode;
  int          cycles;
  int          error_count;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mask of a key field: 0/1 addresses, 2/3 ports, 4 protocol.
  function automatic logic [31:0] field_mask(input int fld);
    case (fld)
      0, 1:    field_mask = 32'hFFFF_FFFF;
      2, 3:    field_mask = 32'h0000_FFFF;
      default: field_mask = 32'h0000_00FF;
    endcase
  endfunction

  // Rules lean on wildcards; packets lean on pool values.
  function automatic logic [31:0] pick_field(input int fld, input bit for_rule);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      pick_field = $urandom & field_mask(fld);
    end else if (for_rule ? (roll < 55) : (roll < 15)) begin
      pick_field = '0;
    end else begin
      pick_field = field_pool[fld][$urandom_range(0, 3)];
    end
  endfunction

  function automatic key_t pick_key(input bit for_rule);
    key_t k;
    k.src_addr = AddrW'(pick_field(0, for_rule));
    k.dst_addr = AddrW'(pick_field(1, for_rule));
    k.sport    = PortW'(pick_field(2, for_rule));
    k.dport    = PortW'(pick_field(3, for_rule));
    k.proto    = ProtoW'(pick_field(4, for_rule));
    return k;
  endfunction

  function automatic cmd_t make_cmd(input op_t op, input key_t k, input logic act,
                                    input logic [RuleIdW-1:0] idx);
    cmd_t c;
    c.op    = op;
    c.key   = k;
    c.act   = act;
    c.idx   = idx;
    c.drain = 1'b0;
    return c;
  endfunction

  // Idle cycles for one beat: none, anything up to 12, or mostly none.
  function automatic int draw_wait(input int mode);
    case (mode)
      0:       draw_wait = 0;
      1:       draw_wait = $urandom_range(0, 12);
      default: draw_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    endcase
  endfunction

  // Apply one command to the shadow table and return the verdict it yields.
  function automatic res_t apply_cmd(input cmd_t c);
    res_t r;
    rule_t rl;
    r = '0;
    r.status = STAT_DONE;
    case (c.op)
      OP_CHECK: begin
        for (int i = 0; i < MaxRules; i++) begin
          rl = shadow_rules[i];
          if (!r.rule_hit && i < shadow_count && rl.enable &&
              (rl.key.src_addr == '0 || rl.key.src_addr == c.key.src_addr) &&
              (rl.key.dst_addr == '0 || rl.key.dst_addr == c.key.dst_addr) &&
              (rl.key.sport == '0 || rl.key.sport == c.key.sport) &&
              (rl.key.dport == '0 || rl.key.dport == c.key.dport) &&
              (rl.key.proto == '0 || rl.key.proto == c.key.proto)) begin
            r.rule_hit  = 1'b1;
            r.hit_index = i[HitW-1:0];
            r.allowed   = rl.action;
          end
        end
      end
      OP_APPEND: begin
        if (shadow_count >= MaxRules) begin
          r.status = STAT_FULL;
        end else begin
          shadow_rules[shadow_count] = '{key: c.key, action: c.act, enable: 1'b1};
          shadow_count = shadow_count + CntW'(1);
        end
      end
      default: begin
        if (c.idx < shadow_count) begin
          shadow_rules[c.idx].enable = (c.op == OP_ENABLE);
        end else begin
          r.status = STAT_RANGE;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Driver: predicts each accepted beat, then holds, idles or presents the next.
  always @(posedge clk) begin : drive_cmds
    bit   took;
    int   gap;
    cmd_t nxt;
    if (!rst_n) begin
      cmd_bus.valid <= 1'b0;
      tx_gap        <= 0;
      shadow_rules[0] = DfltRule;
      shadow_count    = CntW'(1);
    end else begin
      took = cmd_bus.valid && cmd_bus.ready;
      if (took) begin
        expected_verdicts.push_back(apply_cmd(cur_cmd));
      end
      gap = took ? draw_wait(tx_mode) : tx_gap;
      if (cmd_bus.valid && !took) begin
        // Beat not taken yet: keep it on the bus.
      end else if (gap != 0) begin
        cmd_bus.valid <= 1'b0;
        tx_gap        <= gap - 1;
      end else if (pending_cmds.size() != 0 &&
                   (!pending_cmds[0].drain || (!took && expected_verdicts.size() == 0))) begin
        nxt = pending_cmds.pop_front();
        cur_cmd                 <= nxt;
        cmd_bus.valid           <= 1'b1;
        cmd_bus.opcode          <= nxt.op;
        cmd_bus.source_address  <= nxt.key.src_addr;
        cmd_bus.dest_address    <= nxt.key.dst_addr;
        cmd_bus.source_port     <= nxt.key.sport;
        cmd_bus.dest_port       <= nxt.key.dport;
        cmd_bus.protocol_number <= nxt.key.proto;
        cmd_bus.rule_action     <= nxt.act;
        cmd_bus.rule_index      <= nxt.idx;
        tx_gap                  <= 0;
      end else begin
        cmd_bus.valid <= 1'b0;
        tx_gap        <= 0;
      end
    end
  end

  // Monitor: checks each result beat and stalls ready at random.
  always @(posedge clk) begin : watch_results
    res_t want;
    int   stall;
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
      rx_stall      <= 0;
    end else begin
      stall = rx_stall;
      if (res_bus.valid && res_bus.ready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual status %0h",
                   $time, res_bus.status);
          error_count++;
        end else begin
          want = expected_verdicts.pop_front();
          report_field("status", 32'(want.status), 32'(res_bus.status));
          report_field("allowed", 32'(want.allowed), 32'(res_bus.allowed));
          report_field("rule_hit", 32'(want.rule_hit), 32'(res_bus.rule_hit));
          report_field("hit_index", 32'(want.hit_index), 32'(res_bus.hit_index));
        end
        stall = draw_wait(rx_mode);
      end
      if (stall != 0) begin
        res_bus.ready <= 1'b0;
        rx_stall      <= stall - 1;
      end else begin
        res_bus.ready <= 1'b1;
        rx_stall      <= 0;
      end
    end
  end

  // Cycle count, idle mode changes and the run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles[7:0] == 8'd0) begin
      tx_mode <= $urandom_range(0, 2);
      rx_mode <= $urandom_range(0, 2);
    end
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin : main
    key_t zero_key;
    key_t ones_key;
    key_t k;
    cmd_t c;
    int   rules_made;
    int   roll;

    rst_n                   = 1'b0;
    cmd_bus.valid           = 1'b0;
    cmd_bus.opcode          = OP_CHECK;
    cmd_bus.source_address  = '0;
    cmd_bus.dest_address    = '0;
    cmd_bus.source_port     = '0;
    cmd_bus.dest_port       = '0;
    cmd_bus.protocol_number = '0;
    cmd_bus.rule_action     = 1'b0;
    cmd_bus.rule_index      = '0;
    res_bus.ready           = 1'b0;
    cycles                  = 0;
    error_count             = 0;
    tx_mode                 = 1;
    rx_mode                 = 1;

    for (int f = 0; f < 5; f++) begin
      field_pool[f][0] = field_mask(f);
      for (int j = 1; j < 4; j++) begin
        field_pool[f][j] = $urandom & field_mask(f);
        if (field_pool[f][j] == '0) field_pool[f][j] = 32'd1;
      end
    end

    zero_key = '0;
    ones_key = '1;

    // Directed part: default rule, range errors, wildcards, first-match order.
    pending_cmds.push_back(make_cmd(OP_CHECK, zero_key, 1'b0, 4'd0));
    pending_cmds.push_back(make_cmd(OP_CHECK, ones_key, 1'b1, 4'd15));
    pending_cmds.push_back(make_cmd(OP_ENABLE, zero_key, 1'b0, 4'd15));
    pending_cmds.push_back(make_cmd(OP_DISABLE, zero_key, 1'b0, 4'd1));
    pending_cmds.push_back(make_cmd(OP_DISABLE, zero_key, 1'b0, 4'd0));
    pending_cmds.push_back(make_cmd(OP_CHECK, pick_key(1'b0), 1'b0, 4'd0));
    pending_cmds.push_back(make_cmd(OP_APPEND, ones_key, 1'b1, 4'd0));
    pending_cmds.push_back(make_cmd(OP_CHECK, ones_key, 1'b0, 4'd0));
    k = ones_key;
    k.proto = 8'hFE;
    pending_cmds.push_back(make_cmd(OP_CHECK, k, 1'b0, 4'd0));
    pending_cmds.push_back(make_cmd(OP_APPEND, zero_key, 1'b1, 4'd0));
    pending_cmds.push_back(make_cmd(OP_CHECK, zero_key, 1'b0, 4'd0));
    k = zero_key;
    k.src_addr = field_pool[0][1];
    pending_cmds.push_back(make_cmd(OP_APPEND, k, 1'b0, 4'd0));
    k = pick_key(1'b0);
    k.src_addr = field_pool[0][1];
    pending_cmds.push_back(make_cmd(OP_CHECK, k, 1'b0, 4'd0));
    pending_cmds.push_back(make_cmd(OP_DISABLE, zero_key, 1'b0, 4'd2));
    pending_cmds.push_back(make_cmd(OP_CHECK, k, 1'b0, 4'd0));
    k.src_addr = ~field_pool[0][1];
    pending_cmds.push_back(make_cmd(OP_CHECK, k, 1'b0, 4'd0));
    pending_cmds.push_back(make_cmd(OP_ENABLE, zero_key, 1'b0, 4'd0));
    pending_cmds.push_back(make_cmd(OP_CHECK, k, 1'b0, 4'd0));
    pending_cmds.push_back(make_cmd(OP_DISABLE, zero_key, 1'b0, 4'd0));
    pending_cmds.push_back(make_cmd(OP_ENABLE, zero_key, 1'b0, 4'd4));
    pending_cmds.push_back(make_cmd(OP_ENABLE, zero_key, 1'b0, 4'd2));
    pending_cmds.push_back(make_cmd(OP_DISABLE, zero_key, 1'b0, 4'd3));
    rules_made = 4;

    // Random part: mostly checks against a table that fills up over time.
    for (int n = 0; n < RandomCmds; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        c = make_cmd(OP_CHECK, pick_key(1'b0), 1'($urandom), 4'($urandom));
      end else if (roll < 65) begin
        c = make_cmd(OP_APPEND, pick_key(1'b1), 1'($urandom), 4'($urandom));
        if (rules_made < MaxRules) rules_made++;
      end else begin
        c = make_cmd((roll < 82) ? OP_ENABLE : OP_DISABLE, pick_key(1'b0), 1'($urandom),
                     ($urandom_range(0, 4) != 0) ? 4'($urandom_range(0, rules_made - 1))
                                                 : 4'($urandom));
      end
      c.drain = (n == RandomCmds / 2) || ($urandom_range(0, 199) == 0);
      pending_cmds.push_back(c);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every beat to be sent and every result to come back.
    while (pending_cmds.size() != 0 || cmd_bus.valid) @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
